FILE: rtl/core/utf8st_pkg.sv
// Package for the UTF-8 stream transcoder: widths, codes, shared types.
package utf8st_pkg;

   localparam int BYTE_W  = 8;
   localparam int POINT_W = 21;
   localparam int FMT_W   = 2;
   localparam int REPL_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam int UTF8ST_QUEUE_DEPTH = 4;

   localparam logic [FMT_W-1:0] FMT_UTF32 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_UTF16 = 2'd1;
   localparam logic [FMT_W-1:0] FMT_ASCII = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_REPL   = 2'd1;

   localparam logic [FMT_W-1:0]  FMT_RESET  = FMT_UTF32;
   localparam logic [REPL_W-1:0] REPL_RESET = 7'd63;

   localparam logic [POINT_W-1:0] BMP_MAX     = 21'h00FFFF;
   localparam logic [POINT_W-1:0] UNICODE_MAX = 21'h10FFFF;
   localparam logic [POINT_W-1:0] SUPP_BASE   = 21'h010000;
   localparam logic [POINT_W-1:0] ASCII_TOP   = 21'd127;
   localparam logic [15:0]        HI_SURR     = 16'hD800;
   localparam logic [15:0]        LO_SURR     = 16'hDC00;

   typedef struct packed {
      logic [POINT_W-1:0] point;
      logic               err;
   } qentry_type;

   typedef struct packed {
      logic [FMT_W-1:0]  fmt;
      logic [REPL_W-1:0] repl;
   } cfg_type;

endpackage

FILE: rtl/core/utf8_stream_transcoder_top.sv
// Top level of the UTF-8 stream transcoder: config registers and the three stages.
// Latency: a word reaches rsp through the queue and then the output register, after the byte that ends its code point.
// Throughput: one byte accepted per cycle while the queue is not full; a surrogate pair is sent as two words.
// The queue between decoder and formatter absorbs output stalls and pair expansion.
// Reset clears decoder, queue and output state; output_format -> 0, replacement -> 63.
// No clearing pass after reset.
module utf8_stream_transcoder_top #(
   parameter int QUEUE_DEPTH = utf8st_pkg::UTF8ST_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [utf8st_pkg::BYTE_W-1:0]      req_byte_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [utf8st_pkg::POINT_W-1:0]     rsp_unit_out,
   output logic                               rsp_is_error,
   output logic                               rsp_last_unit,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [utf8st_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [utf8st_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import utf8st_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       push;
   qentry_type push_entry;
   logic       pop;
   qentry_type head;
   logic       empty;
   logic       full;

   assign csr_ready = 1'b1;
   assign req_ready = !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_IDX_FORMAT) begin
            cfg_in.fmt = csr_wdata[FMT_W-1:0];
         end else if (csr_index == CSR_IDX_REPL) begin
            cfg_in.repl = csr_wdata[REPL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt  <= FMT_RESET;
         cfg_ff.repl <= REPL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   utf8st_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .push        (push),
      .push_entry  (push_entry)
   );

   utf8st_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   utf8st_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_unit_out  (rsp_unit_out),
      .rsp_is_error  (rsp_is_error),
      .rsp_last_unit (rsp_last_unit)
   );

endmodule

FILE: rtl/core/utf8st_front.sv
// Front end: accepts UTF-8 bytes and assembles code points or error entries.
module utf8st_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [utf8st_pkg::BYTE_W-1:0]   req_byte_in,
   output logic                            push,
   output utf8st_pkg::qentry_type          push_entry
);
   import utf8st_pkg::*;

   logic [POINT_W-1:0] partial_ff, partial_in;
   logic [1:0]         left_ff, left_in;

   always_comb begin
      logic [POINT_W-1:0] cont;
      logic [POINT_W-1:0] shifted;
      logic [POINT_W-1:0] acc;
      cont       = {{(POINT_W-6){1'b0}}, req_byte_in[5:0]};
      shifted    = cont;
      acc        = partial_ff;
      partial_in = partial_ff;
      left_in    = left_ff;
      push       = 1'b0;
      push_entry = '0;
      if (req_valid && req_ready) begin
         if (left_ff != 2'd0) begin
            unique case (left_ff)
               2'd3:    shifted = cont << 12;
               2'd2:    shifted = cont << 6;
               default: shifted = cont;
            endcase
            acc     = partial_ff | shifted;
            left_in = left_ff - 2'd1;
            if (left_ff == 2'd1) begin
               push             = 1'b1;
               push_entry.point = acc;
               partial_in       = '0;
            end else begin
               partial_in = acc;
            end
         end else begin
            priority if (req_byte_in[7] == 1'b0) begin
               push             = 1'b1;
               push_entry.point = {{(POINT_W-BYTE_W){1'b0}}, req_byte_in};
               partial_in       = '0;
            end else if (req_byte_in[7:5] == 3'b110) begin
               partial_in = {{(POINT_W-5){1'b0}}, req_byte_in[4:0]} << 6;
               left_in    = 2'd1;
            end else if (req_byte_in[7:4] == 4'b1110) begin
               partial_in = {{(POINT_W-4){1'b0}}, req_byte_in[3:0]} << 12;
               left_in    = 2'd2;
            end else if (req_byte_in[7:3] == 5'b11110) begin
               partial_in = {{(POINT_W-3){1'b0}}, req_byte_in[2:0]} << 18;
               left_in    = 2'd3;
            end else begin
               push           = 1'b1;
               push_entry.err = 1'b1;
               partial_in     = '0;
               left_in        = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         left_ff    <= 2'd0;
      end else begin
         partial_ff <= partial_in;
         left_ff    <= left_in;
      end
   end

endmodule

FILE: rtl/core/utf8st_queue.sv
// Short queue of decoded entries between the front and back ends.
module utf8st_queue #(
   parameter int DEPTH = utf8st_pkg::UTF8ST_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  utf8st_pkg::qentry_type push_entry,
   input  logic                   pop,
   output utf8st_pkg::qentry_type head,
   output logic                   empty,
   output logic                   full
);
   import utf8st_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   qentry_type         mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not raise count");

endmodule

FILE: rtl/core/utf8st_back.sv
// Back end: formats queued code points into UTF-32, UTF-16 or ASCII words.
module utf8st_back (
   input  logic                             clock,
   input  logic                             reset,
   input  utf8st_pkg::cfg_type              cfg,
   input  utf8st_pkg::qentry_type           head,
   input  logic                             empty,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [utf8st_pkg::POINT_W-1:0]   rsp_unit_out,
   output logic                             rsp_is_error,
   output logic                             rsp_last_unit
);
   import utf8st_pkg::*;

   logic               valid_ff, valid_in;
   logic               lo_pend_ff, lo_pend_in;
   logic [9:0]         lo_bits_ff, lo_bits_in;
   logic [POINT_W-1:0] unit_ff, unit_in;
   logic               err_ff, err_in;
   logic               last_ff, last_in;
   logic               out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign pop      = out_free && !lo_pend_ff && !empty;

   always_comb begin
      logic [POINT_W-1:0] v;
      v          = head.point - SUPP_BASE;
      valid_in   = valid_ff;
      lo_pend_in = lo_pend_ff;
      lo_bits_in = lo_bits_ff;
      unit_in    = unit_ff;
      err_in     = err_ff;
      last_in    = last_ff;
      if (out_free) begin
         if (lo_pend_ff) begin
            valid_in   = 1'b1;
            lo_pend_in = 1'b0;
            unit_in    = {{(POINT_W-16){1'b0}}, LO_SURR | {6'b0, lo_bits_ff}};
            err_in     = 1'b0;
            last_in    = 1'b1;
         end else if (!empty) begin
            valid_in = 1'b1;
            err_in   = 1'b0;
            last_in  = 1'b1;
            unit_in  = head.point;
            if (head.err) begin
               unit_in = '0;
               err_in  = 1'b1;
            end else if (cfg.fmt == FMT_UTF16) begin
               if (head.point > UNICODE_MAX) begin
                  unit_in = '0;
                  err_in  = 1'b1;
               end else if (head.point > BMP_MAX) begin
                  unit_in    = {{(POINT_W-16){1'b0}}, HI_SURR | {6'b0, v[19:10]}};
                  last_in    = 1'b0;
                  lo_pend_in = 1'b1;
                  lo_bits_in = v[9:0];
               end
            end else if (cfg.fmt == FMT_ASCII) begin
               if (head.point > ASCII_TOP) begin
                  unit_in = {{(POINT_W-REPL_W){1'b0}}, cfg.repl};
               end
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         lo_pend_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         lo_pend_ff <= lo_pend_in;
      end
      lo_bits_ff <= lo_bits_in;
      unit_ff    <= unit_in;
      err_ff     <= err_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_unit_out  = unit_ff;
   assign rsp_is_error  = err_ff;
   assign rsp_last_unit = last_ff;

   a_pend_hi_shown: assert property (@(posedge clock) disable iff (reset)
      lo_pend_ff |-> (valid_ff && !last_ff && !err_ff))
      else $error("low surrogate pending without high surrogate shown");

   a_pend_no_pop: assert property (@(posedge clock) disable iff (reset)
      lo_pend_ff |-> !pop)
      else $error("queue popped while low surrogate pending");

endmodule

FILE: tb/utf8_stream_transcoder_top_test.sv
// Self-checking testbench for the UTF-8 stream transcoder: directed table, then random phases.
module utf8_stream_transcoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8st_pkg::*;

   localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

   typedef struct packed {
      logic [POINT_W-1:0] unit_val;
      logic               err;
      logic               last;
   } unit_word_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [BYTE_W-1:0]      octet;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      unit_word_type          word;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_byte_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [POINT_W-1:0]     rsp_unit_out;
   logic                   rsp_is_error;
   logic                   rsp_last_unit;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // typed expectation riding along with the byte on req
   logic           typed_on = 1'b0;
   unit_word_type  typed_word = '0;

   cfg_type             shadow_cfg;
   logic [POINT_W-1:0]  partial_point_q;
   logic [1:0]          bytes_left_q;
   unit_word_type       expected_words [$];
   int                  failures = 0;
   int                  burst_left = 0;
   int                  bytes_sent = 0;
   logic [9:0]          ready_phase = '0;

   utf8_stream_transcoder_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_unit_out  (rsp_unit_out),
      .rsp_is_error  (rsp_is_error),
      .rsp_last_unit (rsp_last_unit),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void format_point(input logic [POINT_W-1:0] cp,
                                        output unit_word_type w0, output unit_word_type w1,
                                        output int n);
      logic [POINT_W-1:0] off;
      w0 = '{cp, 1'b0, 1'b1};
      w1 = '0;
      n  = 1;
      case (shadow_cfg.fmt)
         FMT_UTF16: begin
            if (cp > UNICODE_MAX) begin
               w0 = '{'0, 1'b1, 1'b1};
            end else if (cp > BMP_MAX) begin
               off = cp - SUPP_BASE;
               w0 = '{POINT_W'(HI_SURR | {6'd0, off[19:10]}), 1'b0, 1'b0};
               w1 = '{POINT_W'(LO_SURR | {6'd0, off[9:0]}), 1'b0, 1'b1};
               n  = 2;
            end
         end
         FMT_ASCII: begin
            if (cp > ASCII_TOP) w0.unit_val = POINT_W'(shadow_cfg.repl);
         end
         default: ;
      endcase
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b,
                                       output unit_word_type w0, output unit_word_type w1,
                                       output int n);
      int                 sh;
      logic [POINT_W-1:0] cp;
      w0 = '0;
      w1 = '0;
      n  = 0;
      if (bytes_left_q != 2'd0) begin
         sh = (bytes_left_q == 2'd3) ? 12 : (bytes_left_q == 2'd2) ? 6 : 0;
         partial_point_q = partial_point_q | (POINT_W'(b[5:0]) << sh);
         bytes_left_q = bytes_left_q - 2'd1;
         if (bytes_left_q == 2'd0) begin
            cp = partial_point_q;
            partial_point_q = '0;
            format_point(cp, w0, w1, n);
         end
      end else if (!b[7]) begin
         partial_point_q = '0;
         format_point(POINT_W'(b), w0, w1, n);
      end else if (b[7:5] == 3'b110) begin
         partial_point_q = POINT_W'(b[4:0]) << 6;
         bytes_left_q = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         partial_point_q = POINT_W'(b[3:0]) << 12;
         bytes_left_q = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         partial_point_q = POINT_W'(b[2:0]) << 18;
         bytes_left_q = 2'd3;
      end else begin
         partial_point_q = '0;
         bytes_left_q = 2'd0;
         w0 = '{'0, 1'b1, 1'b1};
         n  = 1;
      end
   endfunction

   // watches accepted bytes and csr writes, queues what rsp must carry
   always @(posedge clock) begin : track_req
      unit_word_type w0, w1;
      int            n;
      if (reset) begin
         shadow_cfg = '{FMT_RESET, REPL_RESET};
         partial_point_q = '0;
         bytes_left_q = 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IDX_FORMAT) shadow_cfg.fmt = csr_wdata[FMT_W-1:0];
            else if (csr_index == CSR_IDX_REPL) shadow_cfg.repl = csr_wdata[REPL_W-1:0];
         end
         if (req_valid && req_ready) begin
            decode_byte(req_byte_in, w0, w1, n);
            if (typed_on) begin
               expected_words.push_back(typed_word);
            end else begin
               if (n > 0) expected_words.push_back(w0);
               if (n > 1) expected_words.push_back(w1);
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      unit_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("rsp word with nothing expected: unit_out %0h", rsp_unit_out);
            failures++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_unit_out !== want.unit_val) begin
               $error("unit_out: expected %0h, actual %0h", want.unit_val, rsp_unit_out);
               failures++;
            end
            if (rsp_is_error !== want.err) begin
               $error("is_error: expected %0b, actual %0b", want.err, rsp_is_error);
               failures++;
            end
            if (rsp_last_unit !== want.last) begin
               $error("last_unit: expected %0b, actual %0b", want.last, rsp_last_unit);
               failures++;
            end
         end
      end
   end

   // receiver: stall pattern set by the top two bits of a free-running phase counter
   always @(posedge clock) begin
      ready_phase <= ready_phase + 10'd1;
      case (ready_phase[9:8])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2:    rsp_ready <= (ready_phase[1:0] == 2'd0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ---------------------------------------------------------------- driving
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                            input unit_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      typed_on    <= typed;
      typed_word  <= w;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      // a lead byte leaves no word behind; let the pipeline settle
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_code_point();
      int unsigned        pick, len, keep;
      logic [POINT_W-1:0] cp;
      logic [BYTE_W-1:0]  seq [4];
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
         return;
      end
      pick = $urandom_range(0, 99);
      len = (pick < 30) ? 1 : (pick < 50) ? 2 : (pick < 70) ? 3 : 4;
      case (len)
         1: cp = POINT_W'($urandom_range(0, 'h7F));
         2: cp = POINT_W'($urandom_range(0, 'h7FF));
         3: cp = POINT_W'($urandom_range(0, 'hFFFF));
         default: cp = ($urandom_range(0, 1) == 1) ? POINT_W'($urandom_range('h10000, 'h10FFFF))
                                                    : POINT_W'($urandom_range(0, 'h1FFFFF));
      endcase
      case (len)
         1: seq[0] = {1'b0, cp[6:0]};
         2: seq[0] = {3'b110, cp[10:6]};
         3: seq[0] = {4'b1110, cp[15:12]};
         default: seq[0] = {5'b11110, cp[20:18]};
      endcase
      for (int k = 1; k < len; k++) begin
         seq[k] = {2'b10, 6'((cp >> (6 * (len - 1 - k))) & 'h3F)};
         if ($urandom_range(0, 9) == 0) seq[k][7:6] = 2'($urandom_range(0, 3));
      end
      keep = len;
      if (len > 1 && $urandom_range(0, 19) == 0) keep = $urandom_range(1, len - 1);
      for (int k = 0; k < keep; k++) send_byte(seq[k], 1'b0, '0);
   endtask

   function automatic script_row_type b_row(input logic [BYTE_W-1:0] b);
      return '{ROW_BYTE, b, '0, '0, '0};
   endfunction

   function automatic script_row_type t_row(input logic [BYTE_W-1:0] b,
                                            input logic [POINT_W-1:0] u,
                                            input logic e, input logic l);
      return '{ROW_TYPED, b, '0, '0, '{u, e, l}};
   endfunction

   function automatic script_row_type c_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      return '{ROW_CSR, '0, idx, val, '0};
   endfunction

   // ---------------------------------------------------------------- sequence
   initial begin : main
      script_row_type     directed_rows [31];
      logic [FMT_W-1:0]   fmt_cycle [4];
      logic [FMT_W-1:0]   fmt;
      logic [REPL_W-1:0]  repl;
      int                 phase_end;

      directed_rows = '{
         // reset config: UTF-32
         t_row(8'h00, 21'h0, 1'b0, 1'b1),
         t_row(8'h7F, 21'h7F, 1'b0, 1'b1),
         t_row(8'h80, 21'h0, 1'b1, 1'b1),     // stray continuation as lead
         t_row(8'hFF, 21'h0, 1'b1, 1'b1),
         t_row(8'hF8, 21'h0, 1'b1, 1'b1),
         b_row(8'hC2), b_row(8'hA9),
         // format switched mid-sequence, then surrogate pair
         b_row(8'hF0), b_row(8'h9F), b_row(8'h98),
         c_row(CSR_IDX_FORMAT, CSR_DATA_W'(FMT_UTF16)),
         b_row(8'h80),
         // above 0x10FFFF in UTF-16
         b_row(8'hF4), b_row(8'h90), b_row(8'h80),
         t_row(8'h80, 21'h0, 1'b1, 1'b1),
         // lone surrogate value passes through
         b_row(8'hED), b_row(8'hA0), b_row(8'h80),
         c_row(CSR_IDX_FORMAT, CSR_DATA_W'(FMT_ASCII)),
         c_row(CSR_IDX_REPL, 7'd127),
         b_row(8'hC3), b_row(8'hBF),
         c_row(CSR_IDX_REPL, 7'd0),
         b_row(8'hC2), b_row(8'h80),
         // unused format, largest 4-byte value
         c_row(CSR_IDX_FORMAT, CSR_DATA_W'(FMT_SPARE)),
         b_row(8'hF7), b_row(8'hBF), b_row(8'hBF), b_row(8'hBF)
      };
      fmt_cycle = '{FMT_UTF32, FMT_UTF16, FMT_ASCII, FMT_SPARE};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CSR:   write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            ROW_TYPED: send_byte(directed_rows[i].octet, 1'b1, directed_rows[i].word);
            default:   send_byte(directed_rows[i].octet, 1'b0, '0);
         endcase
      end

      for (int phase = 0; phase < 8; phase++) begin
         fmt  = (phase < 4) ? fmt_cycle[phase] : fmt_cycle[$urandom_range(0, 3)];
         repl = (phase == 0) ? 7'd0 : (phase == 1) ? 7'd127 : REPL_W'($urandom_range(0, 127));
         write_reg(CSR_IDX_FORMAT, CSR_DATA_W'(fmt));
         write_reg(CSR_IDX_REPL, CSR_DATA_W'(repl));
         phase_end = bytes_sent + 190;
         while (bytes_sent < phase_end) send_code_point();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
